// ----- hw/rtl/ssam_pkg.sv -----
// shared constants, register indexes and types of the strided slice address map
// used by ssam_divider, ssam_linearize and strided_slice_address_map
package ssam_pkg;

  // default geometry: four dimensions of 16-bit sizes
  localparam int unsigned NumDimsDef = 4;
  localparam int unsigned DimBitsDef = 16;

  // flat offsets and configuration words
  localparam int unsigned PosW    = 32;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 2;

  // restoring division steps done in one pipeline stage
  localparam int unsigned DivBitsPerStage = 4;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_INPUT_SIZES  = 2'd0,
    CFG_OUTPUT_SIZES = 2'd1,
    CFG_SLICE_STARTS = 2'd2,
    CFG_SLICE_STEPS  = 2'd3
  } cfg_idx_e;

  // status of an item leaving the divider
  typedef struct packed {
    logic valid;
    logic count_oob;
  } div_ctrl_t;

endpackage

// ----- hw/rtl/ssam_divider.sv -----
// pipelined restoring divider that splits a flat output offset into coordinates
// depends on ssam_pkg
module ssam_divider #(
  parameter int unsigned NUM_DIMS = ssam_pkg::NumDimsDef,
  parameter int unsigned DIM_BITS = ssam_pkg::DimBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [ssam_pkg::PosW-1:0]      pos_i,
  input  logic [NUM_DIMS*DIM_BITS-1:0]   out_sizes_i,
  output ssam_pkg::div_ctrl_t            ctrl_o,
  output logic [NUM_DIMS*DIM_BITS-1:0]   idx_o
);
  import ssam_pkg::*;

  localparam int unsigned StagesPerDim = PosW / DivBitsPerStage;
  localparam int unsigned NumStages    = NUM_DIMS * StagesPerDim;

  logic                         v_q    [NumStages];
  logic [PosW-1:0]              num_q  [NumStages];
  logic [DIM_BITS-1:0]          rem_q  [NumStages];
  logic [NUM_DIMS*DIM_BITS-1:0] idx_q  [NumStages];
  logic                         zero_q [NumStages];

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    // innermost dimension is divided first
    localparam int unsigned Dim   = NUM_DIMS - 1 - s / StagesPerDim;
    localparam int unsigned Lo    = (NUM_DIMS - 1 - Dim) * DIM_BITS;
    localparam bit          First = (s % StagesPerDim) == 0;
    localparam bit          Last  = (s % StagesPerDim) == StagesPerDim - 1;

    logic                         v_in;
    logic [PosW-1:0]              num_in;
    logic [DIM_BITS-1:0]          rem_in;
    logic [NUM_DIMS*DIM_BITS-1:0] idx_in;
    logic                         zero_in;
    logic [DIM_BITS-1:0]          n;
    logic [PosW-1:0]              num_d;
    logic [DIM_BITS-1:0]          rem_d;
    logic [NUM_DIMS*DIM_BITS-1:0] idx_d;
    logic                         zero_d;

    if (s == 0) begin : g_head
      assign v_in    = valid_i;
      assign num_in  = pos_i;
      assign rem_in  = '0;
      assign idx_in  = '0;
      assign zero_in = 1'b0;
    end else begin : g_body
      assign v_in    = v_q[s-1];
      assign num_in  = num_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign idx_in  = idx_q[s-1];
      assign zero_in = zero_q[s-1];
    end

    assign n = out_sizes_i[Lo +: DIM_BITS];

    // a few restoring steps; a zero size passes the offset on undivided
    always_comb begin
      logic [DIM_BITS:0] r;
      logic [PosW-1:0]   num;
      logic              qb;
      r   = First ? '0 : {1'b0, rem_in};
      num = num_in;
      qb  = 1'b0;
      for (int k = 0; k < DivBitsPerStage; k++) begin
        r = {r[DIM_BITS-1:0], num[PosW-1]};
        if (n == '0) begin
          qb = num[PosW-1];
        end else if (r >= {1'b0, n}) begin
          r  = r - {1'b0, n};
          qb = 1'b1;
        end else begin
          qb = 1'b0;
        end
        num = {num[PosW-2:0], qb};
      end
      num_d  = num;
      rem_d  = r[DIM_BITS-1:0];
      idx_d  = idx_in;
      if (Last) begin
        idx_d[Lo +: DIM_BITS] = (n == '0) ? '0 : r[DIM_BITS-1:0];
      end
      zero_d = zero_in | (n == '0);
    end

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    // payload
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s]  <= num_d;
        rem_q[s]  <= rem_d;
        idx_q[s]  <= idx_d;
        zero_q[s] <= zero_d;
      end
    end
  end

  // a quotient left over, or a zero size in any dimension, means the offset lies beyond the output count
  assign ctrl_o.valid     = v_q[NumStages-1];
  assign ctrl_o.count_oob = zero_q[NumStages-1] | (num_q[NumStages-1] != '0);
  assign idx_o            = idx_q[NumStages-1];

endmodule

// ----- hw/rtl/ssam_linearize.sv -----
// coordinate mapping and linearisation over the input sizes, four stages
// depends on ssam_pkg
module ssam_linearize #(
  parameter int unsigned NUM_DIMS = ssam_pkg::NumDimsDef,
  parameter int unsigned DIM_BITS = ssam_pkg::DimBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  ssam_pkg::div_ctrl_t               ctrl_i,
  input  logic [NUM_DIMS*DIM_BITS-1:0]      idx_i,
  input  logic [NUM_DIMS*(DIM_BITS+1)-1:0]  starts_i,
  input  logic [NUM_DIMS*DIM_BITS-1:0]      steps_i,
  input  logic [NUM_DIMS*DIM_BITS-1:0]      in_sizes_i,
  input  logic [NUM_DIMS*ssam_pkg::PosW-1:0] strides_i,
  output logic                              valid_o,
  output logic [ssam_pkg::PosW-1:0]         pos_o,
  output logic                              oob_o
);
  import ssam_pkg::*;

  localparam int unsigned StartW = DIM_BITS + 1;
  localparam int unsigned ProdW  = 2 * DIM_BITS + 1;
  localparam int unsigned CoordW = ProdW + 1;

  logic v1_q, v2_q, v3_q, v4_q;
  logic oob1_q, oob2_q, oob3_q, oob4_q;

  logic signed [ProdW-1:0]  prod_q [NUM_DIMS];
  logic signed [CoordW-1:0] coord_q[NUM_DIMS];
  logic                     bad_q  [NUM_DIMS];
  logic [PosW-1:0]          term_q [NUM_DIMS];
  logic [PosW-1:0]          pos_q;

  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_dim
    localparam int unsigned Lo  = (NUM_DIMS - 1 - d) * DIM_BITS;
    localparam int unsigned SLo = (NUM_DIMS - 1 - d) * StartW;
    localparam int unsigned PLo = (NUM_DIMS - 1 - d) * PosW;

    logic signed [ProdW-1:0]  prod_d;
    logic signed [CoordW-1:0] coord_d;
    logic                     bad_d;
    logic [PosW-1:0]          coord_lo;

    // index times step
    assign prod_d = $signed({1'b0, idx_i[Lo +: DIM_BITS]}) * $signed(steps_i[Lo +: DIM_BITS]);

    // start plus offset, checked against the input size
    assign coord_d = CoordW'($signed(starts_i[SLo +: StartW])) + CoordW'(prod_q[d]);
    assign bad_d   = coord_d[CoordW-1]
                   | (coord_d >= $signed({{(CoordW-DIM_BITS){1'b0}}, in_sizes_i[Lo +: DIM_BITS]}));

    if (CoordW >= PosW) begin : g_cut
      assign coord_lo = coord_q[d][PosW-1:0];
    end else begin : g_ext
      assign coord_lo = {{(PosW-CoordW){coord_q[d][CoordW-1]}}, coord_q[d]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q[d]  <= prod_d;
        coord_q[d] <= coord_d;
        bad_q[d]   <= bad_d;
        term_q[d]  <= coord_lo * strides_i[PLo +: PosW];
      end
    end
  end

  // or of coordinate flags and sum of the terms
  logic            bad_any;
  logic [PosW-1:0] sum_d;
  always_comb begin
    bad_any = 1'b0;
    sum_d   = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      bad_any = bad_any | bad_q[d];
      sum_d   = sum_d + term_q[d];
    end
  end

  // flag path and final sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oob1_q <= ctrl_i.count_oob;
      oob2_q <= oob1_q;
      oob3_q <= oob2_q | bad_any;
      oob4_q <= oob3_q;
      pos_q  <= sum_d;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= ctrl_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign valid_o = v4_q;
  assign pos_o   = pos_q;
  assign oob_o   = oob4_q;

endmodule

// ----- hw/rtl/strided_slice_address_map.sv -----
// throughput: one item per cycle; the whole pipeline holds while a result waits
// the divider does four restoring steps per stage, eight stages per dimension
// reset: configuration registers clear to zero, all valid bits clear
// depends on ssam_pkg, ssam_divider and ssam_linearize
module strided_slice_address_map #(
  parameter int unsigned NUM_DIMS = ssam_pkg::NumDimsDef,
  parameter int unsigned DIM_BITS = ssam_pkg::DimBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [ssam_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ssam_pkg::CfgW-1:0]    cfg_wdata_i,
  // input items
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [31:0]                  s_axis_tdata_i,   // [31:0] out_position
  // result items
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [31:0]                  m_axis_tdata_o,   // [31:0] in_position
  output logic [0:0]                   m_axis_tuser_o    // [0] out_of_bounds
);
  import ssam_pkg::*;

  localparam int unsigned FieldsW = NUM_DIMS * DIM_BITS;
  localparam int unsigned StartW  = DIM_BITS + 1;

  logic [CfgW-1:0] in_sizes_q, out_sizes_q, starts_q, steps_q;
  logic            en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sizes_q  <= '0;
      out_sizes_q <= '0;
      starts_q    <= '0;
      steps_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INPUT_SIZES:  in_sizes_q  <= cfg_wdata_i;
        CFG_OUTPUT_SIZES: out_sizes_q <= cfg_wdata_i;
        CFG_SLICE_STARTS: starts_q    <= cfg_wdata_i;
        CFG_SLICE_STEPS:  steps_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // derived per-dimension values, settled long before an item reaches them
  logic [NUM_DIMS*StartW-1:0] starts_adj;
  logic [NUM_DIMS*PosW-1:0]   strides;

  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_dim
    localparam int unsigned Lo  = (NUM_DIMS - 1 - d) * DIM_BITS;
    localparam int unsigned SLo = (NUM_DIMS - 1 - d) * StartW;
    localparam int unsigned PLo = (NUM_DIMS - 1 - d) * PosW;

    logic [DIM_BITS-1:0] s;
    logic [StartW-1:0]   start_adj_q;

    assign s = starts_q[Lo +: DIM_BITS];

    // negative start counts from the end of the input dimension
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        start_adj_q <= '0;
      end else begin
        start_adj_q <= s[DIM_BITS-1] ? ({s[DIM_BITS-1], s} + {1'b0, in_sizes_q[Lo +: DIM_BITS]})
                                     : {s[DIM_BITS-1], s};
      end
    end
    assign starts_adj[SLo +: StartW] = start_adj_q;

    if (d == NUM_DIMS - 1) begin : g_inner
      assign strides[PLo +: PosW] = PosW'(1);
    end else begin : g_outer
      // stride is the product of all inner input sizes
      localparam int unsigned NLo  = (NUM_DIMS - 2 - d) * DIM_BITS;
      localparam int unsigned NPLo = (NUM_DIMS - 2 - d) * PosW;
      logic [PosW-1:0] stride_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          stride_q <= '0;
        end else begin
          stride_q <= strides[NPLo +: PosW] * PosW'(in_sizes_q[NLo +: DIM_BITS]);
        end
      end
      assign strides[PLo +: PosW] = stride_q;
    end
  end

  // whole pipeline moves unless a result is held
  assign en              = m_axis_tready_i | ~m_axis_tvalid_o;
  assign s_axis_tready_o = en;

  div_ctrl_t          div_ctrl;
  logic [FieldsW-1:0] div_idx;

  ssam_divider #(
    .NUM_DIMS (NUM_DIMS),
    .DIM_BITS (DIM_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (s_axis_tvalid_i),
    .pos_i       (s_axis_tdata_i),
    .out_sizes_i (out_sizes_q[FieldsW-1:0]),
    .ctrl_o      (div_ctrl),
    .idx_o       (div_idx)
  );

  ssam_linearize #(
    .NUM_DIMS (NUM_DIMS),
    .DIM_BITS (DIM_BITS)
  ) u_linearize (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .ctrl_i     (div_ctrl),
    .idx_i      (div_idx),
    .starts_i   (starts_adj),
    .steps_i    (steps_q[FieldsW-1:0]),
    .in_sizes_i (in_sizes_q[FieldsW-1:0]),
    .strides_i  (strides),
    .valid_o    (m_axis_tvalid_o),
    .pos_o      (m_axis_tdata_o),
    .oob_o      (m_axis_tuser_o[0])
  );

`ifndef ASSERT_OFF
  // a held result stalls the input side
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while a result is held");

  // a frozen pipeline keeps its result
  a_frozen_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !s_axis_tready_o) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("result changed while the pipeline was frozen");
`endif

endmodule
